// ===== hw/rtl/owring_pkg.sv =====
// ----------------------------------------------------------------------------
// owring_pkg: shared types and constants for the overwriting ring
// Holds the sequencer states, the operation codes and the fixed field widths.
// ----------------------------------------------------------------------------
package owring_pkg;

  // Fixed field widths
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned TOTAL_W  = 20;
  localparam int unsigned SLOTNO_W = 4;

  // Largest reportable byte total
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Operation codes carried in func
  typedef enum logic {
    FUNC_ADD  = 1'b0,
    FUNC_FIND = 1'b1
  } func_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_WALK,
    ST_HANDLE,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/owring_item_if.sv =====
// ----------------------------------------------------------------------------
// owring_item_if: input channel of the overwriting ring
// Valid/ready channel carrying one add or find request per beat.
// ----------------------------------------------------------------------------
interface owring_item_if;
  import owring_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [HANDLE_W-1:0] entry_handle;
  logic [SIZE_W-1:0]   entry_size;
  logic [OFFSET_W-1:0] byte_offset;

  modport source (
    output valid, func, entry_handle, entry_size, byte_offset,
    input  ready
  );

  modport sink (
    input  valid, func, entry_handle, entry_size, byte_offset,
    output ready
  );

endinterface

// ===== hw/rtl/owring_result_if.sv =====
// ----------------------------------------------------------------------------
// owring_result_if: output channel of the overwriting ring
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface owring_result_if;
  import owring_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic [SLOTNO_W-1:0] slot_index;
  logic [HANDLE_W-1:0] found_handle;
  logic [SIZE_W-1:0]   byte_in_entry;
  logic                evicted_valid;
  logic [HANDLE_W-1:0] evicted_handle;
  logic [TOTAL_W-1:0]  total_bytes;

  modport source (
    output valid, found, slot_index, found_handle, byte_in_entry,
           evicted_valid, evicted_handle, total_bytes,
    input  ready
  );

  modport sink (
    input  valid, found, slot_index, found_handle, byte_in_entry,
           evicted_valid, evicted_handle, total_bytes,
    output ready
  );

endinterface

// ===== hw/rtl/owring_ram.sv =====
// ----------------------------------------------------------------------------
// owring_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module owring_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/overwriting_ring_with_offset_lookup_top.sv =====
// ----------------------------------------------------------------------------
// overwriting_ring_with_offset_lookup_top: ring of handle/length slots
// An add beat passes through ST_ADD, which writes its slot, and ST_DONE,
// which loads the result. A find beat walks the slots in ST_WALK from the
// read index until a hit or the end of the filled ring, fetches the handle
// in ST_HANDLE on a hit and loads the result in ST_DONE; a find on an empty
// ring goes straight to ST_DONE. The walk reads one slot size per cycle from
// the size RAM read port and adds it in a single shared accumulator. The
// result sits in an output register. A new beat is accepted no earlier than
// the cycle after the previous result is loaded there, so the block takes no
// new beat while one is in flight, including while its result waits to load.
// Sizes of slots not yet written read as zero through the fill position of
// the ring, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module overwriting_ring_with_offset_lookup_top #(
  parameter int unsigned SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  owring_item_if.sink     item,
  owring_result_if.source result
);
  import owring_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned SUM_W = SIZE_W + IDX_W;
  localparam int unsigned CMP_W = (SUM_W > OFFSET_W) ? SUM_W : OFFSET_W;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(SLOTS - 1)) r = '0;
    else                        r = i + IDX_W'(1);
    return r;
  endfunction

  // Control state
  state_t            state, state_next;
  logic [IDX_W-1:0]  write_index, read_index;
  logic              ring_full;
  logic [SUM_W-1:0]  stored_bytes;

  // Latched request
  logic                op;
  logic [HANDLE_W-1:0] req_handle;
  logic [SIZE_W-1:0]   req_size;
  logic [OFFSET_W-1:0] req_offset;

  // Walk registers
  logic [IDX_W-1:0]  cur, cur_d;
  logic [CNT_W-1:0]  steps;
  logic [SUM_W-1:0]  cum;

  // Pending result
  logic                res_found;
  logic [SLOTNO_W-1:0] res_slot;
  logic [HANDLE_W-1:0] res_handle;
  logic [SIZE_W-1:0]   res_byte;
  logic                res_ev_valid;
  logic [HANDLE_W-1:0] res_ev_handle;

  // RAM ports
  logic [IDX_W-1:0]    size_raddr, hdl_raddr;
  logic [SIZE_W-1:0]   size_rdata;
  logic [HANDLE_W-1:0] hdl_rdata;
  logic                ram_we;

  logic                accept, empty, out_free, hit, walk_end;
  logic [CMP_W-1:0]    cum_sum, off_ext, byte_diff;
  logic [SIZE_W-1:0]   old_size;
  logic [IDX_W-1:0]    wi_next, ri_next;
  logic [CMP_W-1:0]    total_ext;

  owring_ram #(.WIDTH(SIZE_W), .DEPTH(SLOTS)) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index),
    .wdata (req_size),
    .raddr (size_raddr),
    .rdata (size_rdata)
  );

  owring_ram #(.WIDTH(HANDLE_W), .DEPTH(SLOTS)) u_handle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index),
    .wdata (req_handle),
    .raddr (hdl_raddr),
    .rdata (hdl_rdata)
  );

  // Handshake and shared datapath terms
  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign empty      = (write_index == read_index) && !ring_full;
  assign out_free   = !result.valid || result.ready;
  assign ram_we     = (state == ST_ADD);

  assign off_ext   = CMP_W'(req_offset);
  assign cum_sum   = CMP_W'(cum) + CMP_W'(size_rdata);
  assign byte_diff = off_ext - CMP_W'(cum);
  assign hit       = cum_sum > off_ext;
  assign walk_end  = (next_slot(cur_d) == write_index) || (steps == CNT_W'(SLOTS - 1));

  // The slot at the write index holds data only once the ring is full
  assign old_size = ring_full ? size_rdata : '0;
  assign wi_next  = next_slot(write_index);
  assign ri_next  = ring_full ? next_slot(read_index) : read_index;

  // RAM read addresses
  always_comb begin
    size_raddr = cur;
    hdl_raddr  = write_index;
    unique case (state)
      ST_IDLE: size_raddr = (item.func == FUNC_FIND) ? read_index : write_index;
      ST_WALK: hdl_raddr  = cur_d;
      default: ;
    endcase
  end

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.func == FUNC_ADD) state_next = ST_ADD;
          else if (empty)            state_next = ST_DONE;
          else                       state_next = ST_WALK;
        end
      end
      ST_ADD: state_next = ST_DONE;
      ST_WALK: begin
        if (hit)           state_next = ST_HANDLE;
        else if (walk_end) state_next = ST_DONE;
      end
      ST_HANDLE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and ring control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_index  <= '0;
      read_index   <= '0;
      ring_full    <= 1'b0;
      stored_bytes <= '0;
    end else begin
      state <= state_next;
      if (state == ST_ADD) begin
        write_index  <= wi_next;
        read_index   <= ri_next;
        ring_full    <= ring_full || (wi_next == ri_next);
        stored_bytes <= stored_bytes - SUM_W'(old_size) + SUM_W'(req_size);
      end
    end
  end

  // Request latch, walk and pending result
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op            <= item.func;
          req_handle    <= item.entry_handle;
          req_size      <= item.entry_size;
          req_offset    <= item.byte_offset;
          cur_d         <= read_index;
          cur           <= next_slot(read_index);
          steps         <= '0;
          cum           <= '0;
          res_found     <= 1'b0;
          res_slot      <= '0;
          res_handle    <= '0;
          res_byte      <= '0;
          res_ev_valid  <= 1'b0;
          res_ev_handle <= '0;
        end
      end
      ST_ADD: begin
        res_ev_valid  <= ring_full;
        res_ev_handle <= ring_full ? hdl_rdata : '0;
      end
      ST_WALK: begin
        if (hit) begin
          res_found <= 1'b1;
          res_slot  <= SLOTNO_W'(cur_d);
          res_byte  <= byte_diff[SIZE_W-1:0];
        end else begin
          cum   <= cum_sum[SUM_W-1:0];
          cur_d <= cur;
          cur   <= next_slot(cur);
          steps <= steps + CNT_W'(1);
        end
      end
      ST_HANDLE: res_handle <= hdl_rdata;
      default: ;
    endcase
  end

  // Byte total widened for the saturating compare
  assign total_ext = CMP_W'(stored_bytes);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      result.found          <= res_found;
      result.slot_index     <= res_slot;
      result.found_handle   <= res_handle;
      result.byte_in_entry  <= res_byte;
      result.evicted_valid  <= (op == FUNC_ADD) && res_ev_valid;
      result.evicted_handle <= res_ev_handle;
      result.total_bytes    <= (total_ext > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                               : total_ext[TOTAL_W-1:0];
    end
  end

endmodule
